/* hw/rtl/qte_pkg.sv */
package qte_pkg;

  localparam int QTE_W            = 16;  // field width
  localparam int QTE_OPW          = 36;  // arctangent operand width
  localparam int QTE_VW           = 38;  // cordic vector width
  localparam int QTE_ACCW         = 34;  // angle accumulator width, 2^31 = pi
  localparam int QTE_SQ_BITS      = 29;  // square root result bits
  localparam int QTE_RAD_W        = 2 * QTE_SQ_BITS;
  localparam int QTE_ATAN_LEN     = 24;
  localparam int QTE_CORDIC_STAGES = 16;

  typedef struct packed {
    logic signed [QTE_OPW-1:0] roll_num;
    logic signed [QTE_OPW-1:0] roll_den;
    logic signed [QTE_OPW-1:0] yaw_num;
    logic signed [QTE_OPW-1:0] yaw_den;
  } qte_ops_t;

  typedef struct packed {
    logic lo;  // pitch argument at or below -1
    logic hi;  // pitch argument at or above +1
  } qte_pclamp_t;

  // atan(2^-i), scaled so that 2^31 = pi
  function automatic logic [31:0] qte_atan(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/qte_front.sv */
module qte_front
  import qte_pkg::*;
(
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [QTE_W-1:0]     quat_w,
  input  logic signed [QTE_W-1:0]     quat_x,
  input  logic signed [QTE_W-1:0]     quat_y,
  input  logic signed [QTE_W-1:0]     quat_z,
  output qte_ops_t                    ops,
  output logic signed [QTE_SQ_BITS-1:0] pitch_s,
  output logic [QTE_RAD_W-1:0]        pitch_rad,
  output qte_pclamp_t                 pclamp
);

  localparam logic signed [QTE_OPW-1:0] ONE_Q28 = QTE_OPW'(64'sd268435456);

  // stage a: products
  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, yz_r, wx_r, xz_r, wy_r, xy_r, wz_r;
  logic signed [31:0] ww_nxt, xx_nxt, yy_nxt, zz_nxt, yz_nxt, wx_nxt;
  logic signed [31:0] xz_nxt, wy_nxt, xy_nxt, wz_nxt;

  assign ww_nxt = quat_w * quat_w;
  assign xx_nxt = quat_x * quat_x;
  assign yy_nxt = quat_y * quat_y;
  assign zz_nxt = quat_z * quat_z;
  assign yz_nxt = quat_y * quat_z;
  assign wx_nxt = quat_w * quat_x;
  assign xz_nxt = quat_x * quat_z;
  assign wy_nxt = quat_w * quat_y;
  assign xy_nxt = quat_x * quat_y;
  assign wz_nxt = quat_w * quat_z;

  always_ff @(posedge clk) begin
    if (en) begin
      ww_r <= ww_nxt; xx_r <= xx_nxt; yy_r <= yy_nxt; zz_r <= zz_nxt;
      yz_r <= yz_nxt; wx_r <= wx_nxt; xz_r <= xz_nxt; wy_r <= wy_nxt;
      xy_r <= xy_nxt; wz_r <= wz_nxt;
    end
  end

  // stage b: sums
  qte_ops_t ops_r, ops_nxt;
  logic signed [QTE_OPW-1:0] s_r, s_nxt;

  always_comb begin
    ops_nxt.roll_num = (QTE_OPW'(yz_r) + QTE_OPW'(wx_r)) <<< 1;
    ops_nxt.roll_den = QTE_OPW'(ww_r) - QTE_OPW'(xx_r) - QTE_OPW'(yy_r) + QTE_OPW'(zz_r);
    ops_nxt.yaw_num  = (QTE_OPW'(xy_r) + QTE_OPW'(wz_r)) <<< 1;
    ops_nxt.yaw_den  = QTE_OPW'(ww_r) + QTE_OPW'(xx_r) - QTE_OPW'(yy_r) - QTE_OPW'(zz_r);
    s_nxt            = (QTE_OPW'(wy_r) - QTE_OPW'(xz_r)) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ops_r <= ops_nxt;
      s_r   <= s_nxt;
    end
  end

  // stage c: clamp test and 1 - s^2
  qte_ops_t ops2_r;
  qte_pclamp_t pclamp_r, pclamp_nxt;
  logic signed [QTE_SQ_BITS-1:0] s29_r, s29_nxt;
  logic signed [QTE_RAD_W-1:0] sq;
  logic [QTE_RAD_W-1:0] rad_r, rad_nxt;

  assign pclamp_nxt.lo = (s_r <= -ONE_Q28);
  assign pclamp_nxt.hi = (s_r >= ONE_Q28);
  assign s29_nxt = s_r[QTE_SQ_BITS-1:0];
  assign sq      = s29_nxt * s29_nxt;
  assign rad_nxt = (QTE_RAD_W'(1) << 56) - QTE_RAD_W'(sq);

  always_ff @(posedge clk) begin
    if (en) begin
      ops2_r   <= ops_r;
      pclamp_r <= pclamp_nxt;
      s29_r    <= s29_nxt;
      rad_r    <= rad_nxt;
    end
  end

  assign ops       = ops2_r;
  assign pclamp    = pclamp_r;
  assign pitch_s   = s29_r;
  assign pitch_rad = rad_r;

endmodule

/* hw/rtl/qte_isqrt.sv */
module qte_isqrt
  import qte_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic [QTE_RAD_W-1:0]   rad,
  output logic [QTE_SQ_BITS-1:0] root
);

  localparam int RW = 32;

  logic [QTE_RAD_W-1:0]   rad_r  [QTE_SQ_BITS];
  logic [RW-1:0]          rem_r  [QTE_SQ_BITS];
  logic [QTE_SQ_BITS-1:0] root_r [QTE_SQ_BITS];

  // one result bit per stage, most significant bit pair first
  for (genvar k = 0; k < QTE_SQ_BITS; k++) begin : g_stage
    localparam int P = QTE_SQ_BITS - 1 - k;
    logic [QTE_RAD_W-1:0]   rad_in;
    logic [RW-1:0]          rem_in, rem_sh, trial;
    logic [QTE_SQ_BITS-1:0] root_in;

    if (k == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign rem_sh = {rem_in[RW-3:0], rad_in[2*P+1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k] <= rad_in;
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_in[QTE_SQ_BITS-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_in[QTE_SQ_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[QTE_SQ_BITS-1];

endmodule

/* hw/rtl/qte_cordic.sv */
module qte_cordic
  import qte_pkg::*;
#(
  parameter int STAGES = QTE_CORDIC_STAGES
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [QTE_OPW-1:0] num,
  input  logic signed [QTE_OPW-1:0] den,
  output logic [QTE_W-1:0]          angle
);

  localparam logic signed [QTE_ACCW-1:0] PI_ACC = QTE_ACCW'(64'sd2147483648);

  logic signed [QTE_VW-1:0]   vx_r  [STAGES+1];
  logic signed [QTE_VW-1:0]   vy_r  [STAGES+1];
  logic signed [QTE_ACCW-1:0] acc_r [STAGES+1];
  logic                       zero_r [STAGES+1];

  // pre stage: fold the left half-plane
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (num == '0) && (den == '0);
      if (den < 0) begin
        vx_r[0]  <= -QTE_VW'(den);
        vy_r[0]  <= -QTE_VW'(num);
        acc_r[0] <= (num >= 0) ? PI_ACC : -PI_ACC;
      end else begin
        vx_r[0]  <= QTE_VW'(den);
        vy_r[0]  <= QTE_VW'(num);
        acc_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [QTE_ACCW-1:0] ATAN = QTE_ACCW'(qte_atan(i));
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (vy_r[i] > 0) begin
          vx_r[i+1]  <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1]  <= vy_r[i] - (vx_r[i] >>> i);
          acc_r[i+1] <= acc_r[i] + ATAN;
        end else begin
          vx_r[i+1]  <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1]  <= vy_r[i] + (vx_r[i] >>> i);
          acc_r[i+1] <= acc_r[i] - ATAN;
        end
      end
    end
  end

  logic signed [QTE_ACCW-1:0] rnd;
  assign rnd   = acc_r[STAGES] + QTE_ACCW'(32768);
  assign angle = zero_r[STAGES] ? '0 : rnd[31:16];

endmodule

/* hw/rtl/quaternion_to_euler.sv */
// quaternion to roll, pitch, yaw
// input channel: in_valid/in_ready carries one unit quaternion (w, x, y, z),
//   each signed q1.14 (16384 = 1.0)
// output channel: out_valid/out_ready carries roll, pitch and yaw as signed
//   binary angles (32768 = pi); pitch is clamped to +/- 16384
// pipeline: n is CORDIC_STAGES (capped at 24); 3 product/sum/clamp stages,
//   29 square root stages, 1 cordic set-up stage, n cordic iteration
//   stages and 1 output register
// throughput: one transaction per cycle while the output is not stalled, set by
//   the fully pipelined square root and the three parallel cordic pipelines
// reset: clears all valid bits; payload registers are not reset
// stall: when the output is held and out_ready is low, the whole pipeline
//   freezes and in_ready drops; nothing is lost or duplicated, and bubbles
//   inside the pipeline are not squeezed out
module quaternion_to_euler
  import qte_pkg::*;
#(
  parameter int CORDIC_STAGES = QTE_CORDIC_STAGES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [QTE_W-1:0] in_quat_w,
  input  logic signed [QTE_W-1:0] in_quat_x,
  input  logic signed [QTE_W-1:0] in_quat_y,
  input  logic signed [QTE_W-1:0] in_quat_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [QTE_W-1:0] out_roll_angle,
  output logic signed [QTE_W-1:0] out_pitch_angle,
  output logic signed [QTE_W-1:0] out_yaw_angle
);

  // effective iteration count, table holds 24 entries
  localparam int NS  = (CORDIC_STAGES > QTE_ATAN_LEN) ? QTE_ATAN_LEN : CORDIC_STAGES;
  localparam int CLD = QTE_SQ_BITS + 1 + NS;      // clamp flag delay
  localparam int LAT = 3 + QTE_SQ_BITS + 2 + NS;  // total pipeline depth

  localparam logic signed [QTE_W-1:0] PITCH_POS = 16'sd16384;
  localparam logic signed [QTE_W-1:0] PITCH_NEG = -16'sd16384;

  // global advance: move when the output slot is empty or being taken
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // valid bits travel alongside the data stages
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end
  assign out_valid = vld_r[LAT-1];

  // products, sums, clamp test and 1 - s^2
  qte_ops_t                      f_ops;
  logic signed [QTE_SQ_BITS-1:0] f_s;
  logic [QTE_RAD_W-1:0]          f_rad;
  qte_pclamp_t                   f_pclamp;

  qte_front u_front (
    .clk      (clk),
    .en       (en),
    .quat_w   (in_quat_w),
    .quat_x   (in_quat_x),
    .quat_y   (in_quat_y),
    .quat_z   (in_quat_z),
    .ops      (f_ops),
    .pitch_s  (f_s),
    .pitch_rad(f_rad),
    .pclamp   (f_pclamp)
  );

  // sqrt(1 - s^2) in q.28
  logic [QTE_SQ_BITS-1:0] sq_root;
  qte_isqrt u_isqrt (
    .clk (clk),
    .en  (en),
    .rad (f_rad),
    .root(sq_root)
  );

  // side band delay lines: operands and s match the square root pipeline, clamp flags also the cordic
  qte_ops_t                      ops_d_r [QTE_SQ_BITS];
  logic signed [QTE_SQ_BITS-1:0] s_d_r   [QTE_SQ_BITS];
  qte_pclamp_t                   cl_d_r  [CLD];

  always_ff @(posedge clk) begin
    if (en) begin
      ops_d_r[0] <= f_ops;
      s_d_r[0]   <= f_s;
      cl_d_r[0]  <= f_pclamp;
      for (int k = 1; k < QTE_SQ_BITS; k++) begin
        ops_d_r[k] <= ops_d_r[k-1];
        s_d_r[k]   <= s_d_r[k-1];
      end
      for (int k = 1; k < CLD; k++) begin
        cl_d_r[k] <= cl_d_r[k-1];
      end
    end
  end

  // three parallel arctangent pipelines
  logic [QTE_W-1:0] roll_ang, pitch_ang, yaw_ang;
  logic signed [QTE_OPW-1:0] pitch_num, pitch_den;
  assign pitch_num = QTE_OPW'(s_d_r[QTE_SQ_BITS-1]);
  assign pitch_den = QTE_OPW'({1'b0, sq_root});

  qte_cordic #(.STAGES(NS)) u_roll (
    .clk  (clk),
    .en   (en),
    .num  (ops_d_r[QTE_SQ_BITS-1].roll_num),
    .den  (ops_d_r[QTE_SQ_BITS-1].roll_den),
    .angle(roll_ang)
  );

  qte_cordic #(.STAGES(NS)) u_pitch (
    .clk  (clk),
    .en   (en),
    .num  (pitch_num),
    .den  (pitch_den),
    .angle(pitch_ang)
  );

  qte_cordic #(.STAGES(NS)) u_yaw (
    .clk  (clk),
    .en   (en),
    .num  (ops_d_r[QTE_SQ_BITS-1].yaw_num),
    .den  (ops_d_r[QTE_SQ_BITS-1].yaw_den),
    .angle(yaw_ang)
  );

  // output register, pitch saturation applied here
  logic signed [QTE_W-1:0] roll_r, pitch_r, yaw_r;
  logic signed [QTE_W-1:0] pitch_nxt;

  always_comb begin
    if (cl_d_r[CLD-1].lo) begin
      pitch_nxt = PITCH_NEG;
    end else if (cl_d_r[CLD-1].hi) begin
      pitch_nxt = PITCH_POS;
    end else begin
      pitch_nxt = pitch_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_ang;
      pitch_r <= pitch_nxt;
      yaw_r   <= yaw_ang;
    end
  end

  assign out_roll_angle  = roll_r;
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle   = yaw_r;

`ifndef SYNTHESIS
  // pitch never leaves +/- pi/2
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle >= PITCH_NEG && out_pitch_angle <= PITCH_POS))
    else $error("pitch out of range");

  // a frozen pipeline keeps its valid bits
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved during stall");

  // input is taken exactly when the pipeline advances
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted transaction lost at pipeline entry");
`endif

endmodule
